[rtl/nalsc_pkg.sv]
// Shared types, constants and header decode functions for the Annex B NAL scanner.
// Used by every module of the block; depends on nothing else.
package nalsc_pkg;

  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned OUT_WIDTH   = 32;
  localparam int unsigned NUM_TYPES   = 7;

  localparam int unsigned SLOT_AVC_SPS   = 0;
  localparam int unsigned SLOT_AVC_PPS   = 1;
  localparam int unsigned SLOT_AVC_IDR   = 2;
  localparam int unsigned SLOT_HEVC_VPS  = 3;
  localparam int unsigned SLOT_HEVC_SPS  = 4;
  localparam int unsigned SLOT_HEVC_PPS  = 5;
  localparam int unsigned SLOT_HEVC_IRAP = 6;

  localparam logic [4:0] AVC_TYPE_NONE  = 5'd0;
  localparam logic [4:0] AVC_TYPE_SLICE = 5'd1;
  localparam logic [4:0] AVC_TYPE_IDR   = 5'd5;
  localparam logic [4:0] AVC_TYPE_SEI   = 5'd6;
  localparam logic [4:0] AVC_TYPE_SPS   = 5'd7;
  localparam logic [4:0] AVC_TYPE_PPS   = 5'd8;
  localparam logic [4:0] AVC_TYPE_MAX   = 5'd12;

  localparam logic [5:0] HEVC_TYPE_VPS       = 6'd32;
  localparam logic [5:0] HEVC_TYPE_SPS       = 6'd33;
  localparam logic [5:0] HEVC_TYPE_PPS       = 6'd34;
  localparam logic [5:0] HEVC_TYPE_IRAP_LO   = 6'd16;
  localparam logic [5:0] HEVC_TYPE_IRAP_HI   = 6'd21;

  localparam logic [7:0] START_BYTE = 8'h01;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [OUT_WIDTH-1:0]   out_cnt_t;

  typedef enum logic [1:0] {
    ST_VIDEO     = 2'd0,
    ST_NO_NAL    = 2'd1,
    ST_MALFORMED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CODEC_NONE = 2'd0,
    CODEC_AVC  = 2'd1,
    CODEC_HEVC = 2'd2
  } codec_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    status_e                        status;
    codec_e                         codec;
    out_cnt_t                       byte_total;
    out_cnt_t                       nal_total;
    out_cnt_t [NUM_TYPES-1:0]       type_total;
  } result_t;

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

  function automatic out_cnt_t to_out(cnt_t v);
    logic [63:0] wide;
    wide = 64'(v);
    return wide[OUT_WIDTH-1:0];
  endfunction

  function automatic codec_e header_codec(logic [7:0] h);
    logic [4:0] t4;
    logic [5:0] t5;
    logic       hevc_like;
    logic       avc_core;
    t4 = h[4:0];
    t5 = h[6:1];
    hevc_like = (t5 == HEVC_TYPE_VPS) || (t5 == HEVC_TYPE_SPS) || (t5 == HEVC_TYPE_PPS) ||
                ((t5 >= HEVC_TYPE_IRAP_LO) && (t5 <= HEVC_TYPE_IRAP_HI));
    avc_core = t4 inside {AVC_TYPE_SLICE, AVC_TYPE_IDR, AVC_TYPE_SEI, AVC_TYPE_SPS,
                          AVC_TYPE_PPS};
    if (hevc_like && !avc_core) begin
      return CODEC_HEVC;
    end
    if ((t4 != AVC_TYPE_NONE) && (t4 <= AVC_TYPE_MAX)) begin
      return CODEC_AVC;
    end
    return CODEC_NONE;
  endfunction

  function automatic logic [NUM_TYPES-1:0] type_hits(logic [7:0] h, codec_e c);
    logic [NUM_TYPES-1:0] hits;
    logic [4:0]           t4;
    logic [5:0]           t5;
    hits = '0;
    t4 = h[4:0];
    t5 = h[6:1];
    if (c == CODEC_AVC) begin
      hits[SLOT_AVC_SPS] = (t4 == AVC_TYPE_SPS);
      hits[SLOT_AVC_PPS] = (t4 == AVC_TYPE_PPS);
      hits[SLOT_AVC_IDR] = (t4 == AVC_TYPE_IDR);
    end else if (c == CODEC_HEVC) begin
      hits[SLOT_HEVC_VPS]  = (t5 == HEVC_TYPE_VPS);
      hits[SLOT_HEVC_SPS]  = (t5 == HEVC_TYPE_SPS);
      hits[SLOT_HEVC_PPS]  = (t5 == HEVC_TYPE_PPS);
      hits[SLOT_HEVC_IRAP] = (t5 >= HEVC_TYPE_IRAP_LO) && (t5 <= HEVC_TYPE_IRAP_HI);
    end
    return hits;
  endfunction

endpackage

[rtl/nalsc_in_stage.sv]
// Input register of the NAL scanner: holds one stream word until the core takes it.
// Depends on nalsc_pkg for the item type.
module nalsc_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               take_i,
  output logic               valid_o,
  output nalsc_pkg::item_t   item_o
);
  import nalsc_pkg::*;

  logic  valid_q;
  item_t item_q;
  logic  accept;

  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.data <= data_byte_i;
      item_q.last <= last_byte_i;
    end
  end

endmodule

[rtl/nalsc_core.sv]
// Scanner core: zero-run tracking, header decode, saturating counters and result register.
// Depends on nalsc_pkg for types, codes and the header decode functions.
module nalsc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  nalsc_pkg::item_t    item_i,
  output logic                take_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output nalsc_pkg::result_t  result_o
);
  import nalsc_pkg::*;

  localparam logic [1:0] ZERO_RUN_MAX   = 2'd3;
  localparam logic [1:0] ZERO_RUN_START = 2'd2;

  logic                 pending_q, pending_d;
  logic [1:0]           zrun_q, zrun_d;
  codec_e               codec_q, codec_d;
  logic                 err_q, err_d;
  cnt_t                 byte_q, byte_d;
  cnt_t                 nal_q, nal_d;
  cnt_t [NUM_TYPES-1:0] type_q, type_d;
  logic [NUM_TYPES-1:0] hits;
  codec_e               hdr_codec;
  logic                 fin_err;
  logic                 out_valid_q;
  result_t              res_q, res_d;
  logic                 out_free;
  logic                 load_res;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign take_o      = valid_i && (!item_i.last || out_free);
  assign load_res    = take_o && item_i.last;
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  always_comb begin
    pending_d = pending_q;
    zrun_d    = zrun_q;
    codec_d   = codec_q;
    err_d     = err_q;
    nal_d     = nal_q;
    type_d    = type_q;
    hits      = '0;
    byte_d    = sat_inc(byte_q);
    hdr_codec = header_codec(item_i.data);

    if (pending_q) begin
      pending_d = 1'b0;
      zrun_d    = (item_i.data == ZERO_BYTE) ? 2'd1 : 2'd0;
      if (hdr_codec == CODEC_NONE) begin
        err_d = 1'b1;
      end else if ((codec_q != CODEC_NONE) && (codec_q != hdr_codec)) begin
        err_d = 1'b1;
      end else begin
        codec_d = hdr_codec;
        nal_d   = sat_inc(nal_q);
        hits    = type_hits(item_i.data, hdr_codec);
      end
    end else if ((item_i.data == START_BYTE) && (zrun_q >= ZERO_RUN_START)) begin
      pending_d = 1'b1;
      zrun_d    = 2'd0;
    end else if (item_i.data == ZERO_BYTE) begin
      if (zrun_q != ZERO_RUN_MAX) begin
        zrun_d = zrun_q + 2'd1;
      end
    end else begin
      zrun_d = 2'd0;
    end

    for (int i = 0; i < NUM_TYPES; i++) begin
      if (hits[i]) begin
        type_d[i] = sat_inc(type_q[i]);
      end
    end

    fin_err = err_d || pending_d;
    res_d   = '0;
    if (fin_err) begin
      res_d.status = ST_MALFORMED;
    end else begin
      res_d.status     = ((nal_d != '0) && (codec_d != CODEC_NONE)) ? ST_VIDEO : ST_NO_NAL;
      res_d.codec      = codec_d;
      res_d.byte_total = to_out(byte_d);
      res_d.nal_total  = to_out(nal_d);
      for (int i = 0; i < NUM_TYPES; i++) begin
        res_d.type_total[i] = to_out(type_d[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      zrun_q    <= 2'd0;
      codec_q   <= CODEC_NONE;
      err_q     <= 1'b0;
      byte_q    <= '0;
      nal_q     <= '0;
      type_q    <= '0;
    end else if (take_o) begin
      if (item_i.last) begin
        pending_q <= 1'b0;
        zrun_q    <= 2'd0;
        codec_q   <= CODEC_NONE;
        err_q     <= 1'b0;
        byte_q    <= '0;
        nal_q     <= '0;
        type_q    <= '0;
      end else begin
        pending_q <= pending_d;
        zrun_q    <= zrun_d;
        codec_q   <= codec_d;
        err_q     <= err_d;
        byte_q    <= byte_d;
        nal_q     <= nal_d;
        type_q    <= type_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_res) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      res_q <= res_d;
    end
  end

endmodule

[rtl/annexb_nal_scanner_classifier.sv]
// Top level of the Annex B NAL unit scanner and H.264/H.265 classifier.
// Depends on nalsc_pkg, nalsc_in_stage and nalsc_core.
//
// The input channel carries one stream byte per word with a last-byte flag; a word is
// taken at a rising edge where in_valid_i is high and in_stall_o is low. The output
// channel carries one summary word per stream, produced only for the last byte; it is
// taken at an edge where out_valid_o is high and out_stall_i is low.
// The block sustains one input word per cycle but for a last byte held behind a pending
// summary word. A byte goes through an input register and then one pass through the
// scanner core, which updates the zero-run tracker, the header decode and the saturating
// counters. The summary word is written into the result register when the core takes
// its last byte from the input register, and is held there until the receiver takes it.
// While a summary word waits, bytes of the next stream keep flowing; only a second last
// byte holds in the input register, and then in_stall_o rises, until the pending summary
// is taken.
// Reset clears the scanner state, all counters and both valid flags; no result is
// pending after reset. After each last byte the scanner state and all counters return to reset values.
module annexb_nal_scanner_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [1:0]  codec_o,
  output logic [31:0] byte_total_o,
  output logic [31:0] nal_total_o,
  output logic [31:0] avc_sps_count_o,
  output logic [31:0] avc_pps_count_o,
  output logic [31:0] avc_idr_count_o,
  output logic [31:0] hevc_vps_count_o,
  output logic [31:0] hevc_sps_count_o,
  output logic [31:0] hevc_pps_count_o,
  output logic [31:0] hevc_irap_count_o
);
  import nalsc_pkg::*;

  logic    item_valid;
  item_t   item;
  logic    take;
  result_t result;

  nalsc_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .take_i      (take),
    .valid_o     (item_valid),
    .item_o      (item)
  );

  nalsc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (item_valid),
    .item_i      (item),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign status_o          = result.status;
  assign codec_o           = result.codec;
  assign byte_total_o      = result.byte_total;
  assign nal_total_o       = result.nal_total;
  assign avc_sps_count_o   = result.type_total[SLOT_AVC_SPS];
  assign avc_pps_count_o   = result.type_total[SLOT_AVC_PPS];
  assign avc_idr_count_o   = result.type_total[SLOT_AVC_IDR];
  assign hevc_vps_count_o  = result.type_total[SLOT_HEVC_VPS];
  assign hevc_sps_count_o  = result.type_total[SLOT_HEVC_SPS];
  assign hevc_pps_count_o  = result.type_total[SLOT_HEVC_PPS];
  assign hevc_irap_count_o = result.type_total[SLOT_HEVC_IRAP];

endmodule
